[design/jsv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the JSON syntax validator.
// No dependencies; used by jsv_kind_stack and json_syntax_validator_core.
package jsv_pkg;

  // Parser mode, one-hot
  typedef enum logic [20:0] {
    MODE_VALUE          = 21'h000001,
    MODE_VALUE_OR_CLOSE = 21'h000002,
    MODE_KEY_OR_CLOSE   = 21'h000004,
    MODE_KEY            = 21'h000008,
    MODE_COLON          = 21'h000010,
    MODE_AFTER          = 21'h000020,
    MODE_VSTR           = 21'h000040,
    MODE_VESC           = 21'h000080,
    MODE_VHEX           = 21'h000100,
    MODE_KSTR           = 21'h000200,
    MODE_KESC           = 21'h000400,
    MODE_KHEX           = 21'h000800,
    MODE_LIT            = 21'h001000,
    MODE_NUM_MINUS      = 21'h002000,
    MODE_NUM_ZERO       = 21'h004000,
    MODE_NUM_INT        = 21'h008000,
    MODE_NUM_DOT        = 21'h010000,
    MODE_NUM_FRAC       = 21'h020000,
    MODE_NUM_EXP        = 21'h040000,
    MODE_NUM_ESIGN      = 21'h080000,
    MODE_NUM_EDIG       = 21'h100000
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_RUNNING  = 2'd0,
    STATUS_ACCEPTED = 2'd1,
    STATUS_ERROR    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2
  } lit_e;

  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_ONE        = 8'h31;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LO_A       = 8'h61;
  localparam logic [7:0] CH_LO_B       = 8'h62;
  localparam logic [7:0] CH_LO_E       = 8'h65;
  localparam logic [7:0] CH_LO_F       = 8'h66;
  localparam logic [7:0] CH_LO_N       = 8'h6E;
  localparam logic [7:0] CH_LO_R       = 8'h72;
  localparam logic [7:0] CH_LO_T       = 8'h74;
  localparam logic [7:0] CH_LO_U       = 8'h75;
  localparam logic [7:0] CH_UP_A       = 8'h41;
  localparam logic [7:0] CH_UP_E       = 8'h45;
  localparam logic [7:0] CH_UP_F       = 8'h46;

  // Stack operation from the parser to the container-kind stack
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stack_op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [2:0] lit_len(input lit_e kind);
    logic [2:0] len;
    case (kind)
      LIT_NULL:  len = 3'd4;
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input lit_e kind, input logic [2:0] idx);
    logic [39:0] text;
    logic [7:0]  c;
    case (kind)
      LIT_NULL:  text = {"null", 8'h00};
      LIT_TRUE:  text = {"true", 8'h00};
      LIT_FALSE: text = "false";
      default:   text = '0;
    endcase
    case (idx)
      3'd0:    c = text[39:32];
      3'd1:    c = text[31:24];
      3'd2:    c = text[23:16];
      3'd3:    c = text[15:8];
      3'd4:    c = text[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/json_syntax_validator_core.sv]
`timescale 1ns / 1ps
// JSON well-formedness checker, one document byte per transaction.
// Depends on jsv_pkg and jsv_kind_stack.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | data_byte_i, last_byte_i
//  out     | source    | out_valid_o / out_stall_i  | status_o, error_offset_o,
//          |           |                            | nesting_level_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_data_i (depth_limit)
//
// One byte per cycle sustained while the output does not stall. A byte is captured in the input register,
// is parsed by the mode logic and lands in the result register when stage one advances.
// The single-step mode and stack update sets the rate.
// Reset (rst_ni low, asynchronous) empties both stages, sets depth_limit to 24
// and starts a fresh document. A stall on the output holds the result register;
// the input register then holds too and in_stall_o rises only while both are full.
module json_syntax_validator_core #(
  parameter int STACK_DEPTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] error_offset_o,
  output logic [4:0]  nesting_level_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int CmpW = ((CntW > 5) ? CntW : 5) + 1;
  localparam logic [4:0] DEPTH_LIMIT_RST = 5'd24;

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic        out_advance;
  logic        in_accept;

  // Advance stage one into the result register unless that register is held
  assign out_advance = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the byte of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and document state
  // ---------------------------------------------------------------------------
  logic [4:0]      depth_limit_q;
  jsv_pkg::mode_e  mode_q;
  logic [CntW-1:0] count_q;
  logic [2:0]      hex_q;
  logic [2:0]      lit_idx_q;
  jsv_pkg::lit_e   lit_kind_q;
  logic [31:0]     pos_q;
  logic            err_q;
  logic [31:0]     first_q;

  logic            top_kind;
  logic            has_top;
  jsv_pkg::stack_op_t stack_op;

  assign has_top = (count_q != '0);

  // ---------------------------------------------------------------------------
  // Start of a value: shared by every mode that expects one
  // ---------------------------------------------------------------------------
  logic            sv_ok;
  jsv_pkg::mode_e  sv_mode;
  logic            sv_push;
  logic            sv_kind;
  jsv_pkg::lit_e   sv_lit_kind;
  logic [2:0]      sv_lit_idx;
  logic [CmpW-1:0] eff_limit;
  logic            depth_ok;
  logic [7:0]      c;

  assign c = s1_byte_q;

  always_comb begin
    eff_limit = (CmpW'(depth_limit_q) < CmpW'(STACK_DEPTH)) ? CmpW'(depth_limit_q)
                                                            : CmpW'(STACK_DEPTH);
    depth_ok    = (CmpW'(count_q) + CmpW'(1)) <= eff_limit;
    sv_ok       = 1'b0;
    sv_mode     = mode_q;
    sv_push     = 1'b0;
    sv_kind     = jsv_pkg::KIND_ARRAY;
    sv_lit_kind = lit_kind_q;
    sv_lit_idx  = lit_idx_q;
    if (depth_ok) begin
      if (c == jsv_pkg::CH_QUOTE) begin
        sv_ok   = 1'b1;
        sv_mode = jsv_pkg::MODE_VSTR;
      end else if (c == jsv_pkg::CH_LBRACE) begin
        sv_ok   = 1'b1;
        sv_push = 1'b1;
        sv_kind = jsv_pkg::KIND_OBJECT;
        sv_mode = jsv_pkg::MODE_KEY_OR_CLOSE;
      end else if (c == jsv_pkg::CH_LBRACKET) begin
        sv_ok   = 1'b1;
        sv_push = 1'b1;
        sv_kind = jsv_pkg::KIND_ARRAY;
        sv_mode = jsv_pkg::MODE_VALUE_OR_CLOSE;
      end else if (c == jsv_pkg::CH_LO_N || c == jsv_pkg::CH_LO_T ||
                   c == jsv_pkg::CH_LO_F) begin
        sv_ok       = 1'b1;
        sv_lit_kind = (c == jsv_pkg::CH_LO_N) ? jsv_pkg::LIT_NULL :
                      (c == jsv_pkg::CH_LO_T) ? jsv_pkg::LIT_TRUE : jsv_pkg::LIT_FALSE;
        sv_lit_idx  = 3'd1;
        sv_mode     = jsv_pkg::MODE_LIT;
      end else if (c == jsv_pkg::CH_MINUS) begin
        sv_ok   = 1'b1;
        sv_mode = jsv_pkg::MODE_NUM_MINUS;
      end else if (c == jsv_pkg::CH_ZERO) begin
        sv_ok   = 1'b1;
        sv_mode = jsv_pkg::MODE_NUM_ZERO;
      end else if (c >= jsv_pkg::CH_ONE && c <= jsv_pkg::CH_NINE) begin
        sv_ok   = 1'b1;
        sv_mode = jsv_pkg::MODE_NUM_INT;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // After a value: whitespace, separator or close of the enclosing container
  // ---------------------------------------------------------------------------
  logic           av_ok;
  jsv_pkg::mode_e av_mode;
  logic           av_pop;

  always_comb begin
    av_ok   = 1'b0;
    av_mode = jsv_pkg::MODE_AFTER;
    av_pop  = 1'b0;
    if (jsv_pkg::is_ws(c)) begin
      av_ok = 1'b1;
    end else if (c == jsv_pkg::CH_COMMA && has_top) begin
      av_ok   = 1'b1;
      av_mode = (top_kind == jsv_pkg::KIND_OBJECT) ? jsv_pkg::MODE_KEY : jsv_pkg::MODE_VALUE;
    end else if ((c == jsv_pkg::CH_RBRACKET && has_top && top_kind == jsv_pkg::KIND_ARRAY) ||
                 (c == jsv_pkg::CH_RBRACE && has_top && top_kind == jsv_pkg::KIND_OBJECT)) begin
      av_ok  = 1'b1;
      av_pop = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-mode step
  // ---------------------------------------------------------------------------
  logic            ok;
  jsv_pkg::mode_e  mode_n;
  logic [2:0]      hex_n;
  logic [2:0]      hex_dec;
  logic [2:0]      lit_idx_n;
  logic [2:0]      lit_idx_inc;
  jsv_pkg::lit_e   lit_kind_n;
  logic            push;
  logic            pop;
  logic            push_kind;
  logic            is_key;
  logic            is_exp;

  always_comb begin
    ok          = 1'b0;
    mode_n      = mode_q;
    hex_n       = hex_q;
    lit_idx_n   = lit_idx_q;
    lit_kind_n  = lit_kind_q;
    push        = 1'b0;
    pop         = 1'b0;
    push_kind   = jsv_pkg::KIND_ARRAY;
    is_key      = (mode_q == jsv_pkg::MODE_KSTR) || (mode_q == jsv_pkg::MODE_KESC) ||
                  (mode_q == jsv_pkg::MODE_KHEX);
    is_exp      = (c == jsv_pkg::CH_LO_E) || (c == jsv_pkg::CH_UP_E);
    hex_dec     = (hex_q != 3'd0) ? hex_q - 3'd1 : 3'd0;
    lit_idx_inc = lit_idx_q + 3'd1;

    unique case (mode_q) inside
      jsv_pkg::MODE_VALUE: begin
        if (jsv_pkg::is_ws(c)) begin
          ok = 1'b1;
        end else begin
          ok         = sv_ok;
          mode_n     = sv_mode;
          push       = sv_push;
          push_kind  = sv_kind;
          lit_kind_n = sv_lit_kind;
          lit_idx_n  = sv_lit_idx;
        end
      end
      jsv_pkg::MODE_VALUE_OR_CLOSE: begin
        if (jsv_pkg::is_ws(c)) begin
          ok = 1'b1;
        end else if (c == jsv_pkg::CH_RBRACKET) begin
          ok     = 1'b1;
          pop    = 1'b1;
          mode_n = jsv_pkg::MODE_AFTER;
        end else begin
          ok         = sv_ok;
          mode_n     = sv_mode;
          push       = sv_push;
          push_kind  = sv_kind;
          lit_kind_n = sv_lit_kind;
          lit_idx_n  = sv_lit_idx;
        end
      end
      jsv_pkg::MODE_KEY_OR_CLOSE: begin
        if (jsv_pkg::is_ws(c)) begin
          ok = 1'b1;
        end else if (c == jsv_pkg::CH_RBRACE) begin
          ok     = 1'b1;
          pop    = 1'b1;
          mode_n = jsv_pkg::MODE_AFTER;
        end else if (c == jsv_pkg::CH_QUOTE) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_KSTR;
        end
      end
      jsv_pkg::MODE_KEY: begin
        if (jsv_pkg::is_ws(c)) begin
          ok = 1'b1;
        end else if (c == jsv_pkg::CH_QUOTE) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_KSTR;
        end
      end
      jsv_pkg::MODE_COLON: begin
        if (jsv_pkg::is_ws(c)) begin
          ok = 1'b1;
        end else if (c == jsv_pkg::CH_COLON) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_VALUE;
        end
      end
      jsv_pkg::MODE_AFTER: begin
        ok     = av_ok;
        mode_n = av_mode;
        pop    = av_pop;
      end
      jsv_pkg::MODE_VSTR, jsv_pkg::MODE_KSTR: begin
        if (c == jsv_pkg::CH_QUOTE) begin
          ok     = 1'b1;
          mode_n = is_key ? jsv_pkg::MODE_COLON : jsv_pkg::MODE_AFTER;
        end else if (c >= jsv_pkg::CH_CTRL_LIMIT) begin
          ok = 1'b1;
          if (c == jsv_pkg::CH_BSLASH) begin
            mode_n = is_key ? jsv_pkg::MODE_KESC : jsv_pkg::MODE_VESC;
          end
        end
      end
      jsv_pkg::MODE_VESC, jsv_pkg::MODE_KESC: begin
        if (c == jsv_pkg::CH_LO_U) begin
          ok     = 1'b1;
          hex_n  = jsv_pkg::HEX_DIGITS;
          mode_n = is_key ? jsv_pkg::MODE_KHEX : jsv_pkg::MODE_VHEX;
        end else if (c == jsv_pkg::CH_LO_N || c == jsv_pkg::CH_LO_R ||
                     c == jsv_pkg::CH_LO_T || c == jsv_pkg::CH_LO_B ||
                     c == jsv_pkg::CH_LO_F || c == jsv_pkg::CH_QUOTE ||
                     c == jsv_pkg::CH_BSLASH || c == jsv_pkg::CH_SLASH) begin
          ok     = 1'b1;
          mode_n = is_key ? jsv_pkg::MODE_KSTR : jsv_pkg::MODE_VSTR;
        end
      end
      jsv_pkg::MODE_VHEX, jsv_pkg::MODE_KHEX: begin
        if (jsv_pkg::is_hex(c)) begin
          ok    = 1'b1;
          hex_n = hex_dec;
          if (hex_dec == 3'd0) begin
            mode_n = is_key ? jsv_pkg::MODE_KSTR : jsv_pkg::MODE_VSTR;
          end
        end
      end
      jsv_pkg::MODE_LIT: begin
        if (lit_idx_q < jsv_pkg::lit_len(lit_kind_q) &&
            c == jsv_pkg::lit_char(lit_kind_q, lit_idx_q)) begin
          ok        = 1'b1;
          lit_idx_n = lit_idx_inc;
          if (lit_idx_inc == jsv_pkg::lit_len(lit_kind_q)) begin
            lit_idx_n = 3'd0;
            mode_n    = jsv_pkg::MODE_AFTER;
          end
        end
      end
      jsv_pkg::MODE_NUM_MINUS: begin
        if (c == jsv_pkg::CH_ZERO) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_ZERO;
        end else if (c >= jsv_pkg::CH_ONE && c <= jsv_pkg::CH_NINE) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_INT;
        end
      end
      jsv_pkg::MODE_NUM_ZERO, jsv_pkg::MODE_NUM_INT: begin
        if (mode_q == jsv_pkg::MODE_NUM_INT && jsv_pkg::is_digit(c)) begin
          ok = 1'b1;
        end else if (c == jsv_pkg::CH_DOT) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_DOT;
        end else if (is_exp) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_EXP;
        end else begin
          ok     = av_ok;
          mode_n = av_mode;
          pop    = av_pop;
        end
      end
      jsv_pkg::MODE_NUM_DOT: begin
        if (jsv_pkg::is_digit(c)) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_FRAC;
        end
      end
      jsv_pkg::MODE_NUM_FRAC: begin
        if (jsv_pkg::is_digit(c)) begin
          ok = 1'b1;
        end else if (is_exp) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_EXP;
        end else begin
          ok     = av_ok;
          mode_n = av_mode;
          pop    = av_pop;
        end
      end
      jsv_pkg::MODE_NUM_EXP: begin
        if (c == jsv_pkg::CH_PLUS || c == jsv_pkg::CH_MINUS) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_ESIGN;
        end else if (jsv_pkg::is_digit(c)) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_EDIG;
        end
      end
      jsv_pkg::MODE_NUM_ESIGN: begin
        if (jsv_pkg::is_digit(c)) begin
          ok     = 1'b1;
          mode_n = jsv_pkg::MODE_NUM_EDIG;
        end
      end
      jsv_pkg::MODE_NUM_EDIG: begin
        if (jsv_pkg::is_digit(c)) begin
          ok = 1'b1;
        end else begin
          ok     = av_ok;
          mode_n = av_mode;
          pop    = av_pop;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result and end-of-document checks
  // ---------------------------------------------------------------------------
  logic            apply;
  logic [CntW-1:0] count_n;
  logic [31:0]     pos_next;
  logic            err_f;
  logic [31:0]     first_f;
  jsv_pkg::status_e status_f;
  logic            done;

  // Only a clean byte on a clean document moves the parser state
  assign apply    = !err_q && ok;
  assign pos_next = (&pos_q) ? pos_q : pos_q + 32'd1;

  always_comb begin
    count_n = count_q;
    if (apply && push) begin
      count_n = count_q + CntW'(1);
    end else if (apply && pop) begin
      count_n = count_q - CntW'(1);
    end
  end

  always_comb begin
    done = (count_n == '0) &&
           ((mode_n == jsv_pkg::MODE_AFTER) || (mode_n == jsv_pkg::MODE_NUM_ZERO) ||
            (mode_n == jsv_pkg::MODE_NUM_INT) || (mode_n == jsv_pkg::MODE_NUM_FRAC) ||
            (mode_n == jsv_pkg::MODE_NUM_EDIG));
    err_f    = err_q || !ok;
    first_f  = (!err_q && !ok) ? pos_q : first_q;
    status_f = jsv_pkg::STATUS_RUNNING;
    if (s1_last_q && !err_f) begin
      if (done) begin
        status_f = jsv_pkg::STATUS_ACCEPTED;
      end else begin
        // unfinished document: blame the position one past the last byte
        err_f   = 1'b1;
        first_f = pos_next;
      end
    end
    if (err_f) begin
      status_f = jsv_pkg::STATUS_ERROR;
    end
  end

  assign stack_op.push = out_advance && apply && push;
  assign stack_op.pop  = out_advance && apply && pop;
  assign stack_op.kind = push_kind;

  jsv_kind_stack #(
    .Depth (STACK_DEPTH)
  ) u_kind_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (stack_op),
    .top_o  (top_kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DEPTH_LIMIT_RST;
      mode_q        <= jsv_pkg::MODE_VALUE;
      count_q       <= '0;
      hex_q         <= 3'd0;
      lit_idx_q     <= 3'd0;
      lit_kind_q    <= jsv_pkg::LIT_NULL;
      pos_q         <= 32'd0;
      err_q         <= 1'b0;
      first_q       <= 32'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        depth_limit_q <= cfg_data_i;
      end
      if (out_advance) begin
        if (s1_last_q) begin
          // drop the finished document and start afresh
          mode_q     <= jsv_pkg::MODE_VALUE;
          count_q    <= '0;
          hex_q      <= 3'd0;
          lit_idx_q  <= 3'd0;
          lit_kind_q <= jsv_pkg::LIT_NULL;
          pos_q      <= 32'd0;
          err_q      <= 1'b0;
          first_q    <= 32'd0;
        end else begin
          pos_q   <= pos_next;
          err_q   <= err_f;
          first_q <= first_f;
          count_q <= count_n;
          if (apply) begin
            mode_q     <= mode_n;
            hex_q      <= hex_n;
            lit_idx_q  <= lit_idx_n;
            lit_kind_q <= lit_kind_n;
          end
        end
      end
    end
  end

  // Result register: holds while the consumer stalls
  logic [1:0]  status_q;
  logic [31:0] err_off_q;
  logic [4:0]  nest_q;

  always_ff @(posedge clk_i) begin
    if (out_advance) begin
      status_q  <= status_f;
      err_off_q <= err_f ? first_f : 32'd0;
      nest_q    <= 5'(count_n);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign error_offset_o  = err_off_q;
  assign nesting_level_o = nest_q;

endmodule

[design/jsv_kind_stack.sv]
`timescale 1ns / 1ps
// Container-kind bit stack (object or array) built as a shift line.
// Depends on jsv_pkg for the stack operation struct.
module jsv_kind_stack #(
  parameter int Depth = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jsv_pkg::stack_op_t  op_i,
  output logic                top_o
);

  logic [Depth-1:0] stack_q;
  logic [Depth-1:0] stack_d;

  // Top of stack always sits in bit 0
  always_comb begin
    stack_d = stack_q;
    if (op_i.push) begin
      stack_d = (stack_q << 1) | Depth'(op_i.kind);
    end else if (op_i.pop) begin
      stack_d = stack_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q <= '0;
    end else begin
      stack_q <= stack_d;
    end
  end

  assign top_o = stack_q[0];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for json_syntax_validator_core: documents, back-pressure, depth limits.
// Depends on jsv_pkg and the core RTL; holds its own byte-level parser to predict each result.
module tb_top;
  import jsv_pkg::*;

  localparam int STACK_DEPTH = 24;
  // A result passes the input register and the result register; let it settle before idle-only actions.
  localparam int SETTLE_CYCLES = 4;
  localparam int RUN_LIMIT_NS = 400_000;

  typedef struct packed {
    status_e     status;
    logic [31:0] offset;
    logic [4:0]  level;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] error_offset_o;
  logic [4:0]  nesting_level_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  json_syntax_validator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .error_offset_o (error_offset_o),
    .nesting_level_o(nesting_level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  verdict_t    verdicts_due[$];   // predicted results, oldest first
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned send_gap_pct = 0;  // chance per cycle that the byte source idles
  int unsigned stall_pct = 0;     // chance per cycle that the result sink stalls
  int unsigned hold_req = 0;      // request for a long sink hold-off, in cycles
  int unsigned hold_left = 0;
  logic [4:0]  gen_limit = 5'd24; // limit last written, used to shape nesting
  logic [7:0]  doc_buf[$];        // document being built or sent

  // ---------------------------------------------------------------------------
  // Parser shadow: mode, container-kind stack and first-error capture
  // ---------------------------------------------------------------------------
  mode_e       doc_mode;
  logic        open_kinds[STACK_DEPTH];
  int unsigned open_n;
  int unsigned hex_left;
  int unsigned lit_pos;
  lit_e        lit_sel;
  logic [31:0] doc_offset;
  logic        doc_failed;
  logic [31:0] fail_offset;
  logic [4:0]  depth_lim = 5'd24;

  function automatic void forget_document();
    doc_mode = MODE_VALUE;
    foreach (open_kinds[i]) open_kinds[i] = KIND_ARRAY;
    open_n = 0;
    hex_left = 0;
    lit_pos = 0;
    lit_sel = LIT_NULL;
    doc_offset = '0;
    doc_failed = 1'b0;
    fail_offset = '0;
  endfunction

  function automatic logic ws_byte(logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic dec_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic hex_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
  endfunction

  function automatic int unsigned literal_length(lit_e k);
    return (k == LIT_FALSE) ? 5 : 4;
  endfunction

  function automatic logic [7:0] literal_letter(lit_e k, int unsigned i);
    string w;
    case (k)
      LIT_NULL: w = "null";
      LIT_TRUE: w = "true";
      default:  w = "false";
    endcase
    return (i < w.len()) ? w[i] : 8'h00;
  endfunction

  // First byte of a value; refuse it when its level would pass the effective limit.
  function automatic logic open_value(logic [7:0] c);
    int unsigned room;
    room = (depth_lim < STACK_DEPTH) ? depth_lim : STACK_DEPTH;
    if (open_n + 1 > room) return 1'b0;
    if (c == CH_QUOTE) begin
      doc_mode = MODE_VSTR;
      return 1'b1;
    end
    if (c == CH_LBRACE || c == CH_LBRACKET) begin
      open_kinds[open_n] = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
      open_n++;
      doc_mode = (c == CH_LBRACE) ? MODE_KEY_OR_CLOSE : MODE_VALUE_OR_CLOSE;
      return 1'b1;
    end
    if (c == CH_LO_N || c == CH_LO_T || c == CH_LO_F) begin
      lit_sel = (c == CH_LO_N) ? LIT_NULL : ((c == CH_LO_T) ? LIT_TRUE : LIT_FALSE);
      lit_pos = 1;
      doc_mode = MODE_LIT;
      return 1'b1;
    end
    if (c == CH_MINUS) begin
      doc_mode = MODE_NUM_MINUS;
      return 1'b1;
    end
    if (c == CH_ZERO) begin
      doc_mode = MODE_NUM_ZERO;
      return 1'b1;
    end
    if (c inside {[CH_ONE:CH_NINE]}) begin
      doc_mode = MODE_NUM_INT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Byte after a complete value: whitespace, a separator or the matching close.
  function automatic logic value_done(logic [7:0] c);
    logic in_any, in_obj;
    in_any = (open_n != 0);
    if (in_any) in_obj = (open_kinds[open_n - 1] == KIND_OBJECT);
    else in_obj = 1'b0;
    doc_mode = MODE_AFTER;
    if (ws_byte(c)) return 1'b1;
    if (c == CH_COMMA && in_any) begin
      doc_mode = in_obj ? MODE_KEY : MODE_VALUE;
      return 1'b1;
    end
    if (in_any && ((c == CH_RBRACKET && !in_obj) || (c == CH_RBRACE && in_obj))) begin
      open_n--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic string_step(logic [7:0] c, logic key);
    mode_e body, esc, hex;
    body = key ? MODE_KSTR : MODE_VSTR;
    esc  = key ? MODE_KESC : MODE_VESC;
    hex  = key ? MODE_KHEX : MODE_VHEX;
    if (doc_mode == body) begin
      if (c == CH_QUOTE) begin
        doc_mode = key ? MODE_COLON : MODE_AFTER;
        return 1'b1;
      end
      if (c < CH_CTRL_LIMIT) return 1'b0;
      if (c == CH_BSLASH) doc_mode = esc;
      return 1'b1;
    end
    if (doc_mode == esc) begin
      if (c == CH_LO_U) begin
        hex_left = 4;
        doc_mode = hex;
        return 1'b1;
      end
      case (c)
        CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_B, CH_LO_F, CH_QUOTE, CH_BSLASH, CH_SLASH: begin
          doc_mode = body;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    end
    if (!hex_digit(c)) return 1'b0;
    if (hex_left > 0) hex_left--;
    if (hex_left == 0) doc_mode = body;
    return 1'b1;
  endfunction

  // Advance the shadow parser by one byte; return 0 when the byte is a syntax error.
  function automatic logic take_byte(logic [7:0] c);
    logic exp_mark;
    exp_mark = (c == CH_LO_E) || (c == CH_UP_E);
    case (doc_mode)
      MODE_VALUE: begin
        if (ws_byte(c)) return 1'b1;
        return open_value(c);
      end
      MODE_VALUE_OR_CLOSE: begin
        if (ws_byte(c)) return 1'b1;
        if (c == CH_RBRACKET) begin
          open_n--;
          doc_mode = MODE_AFTER;
          return 1'b1;
        end
        return open_value(c);
      end
      MODE_KEY_OR_CLOSE: begin
        if (ws_byte(c)) return 1'b1;
        if (c == CH_RBRACE) begin
          open_n--;
          doc_mode = MODE_AFTER;
          return 1'b1;
        end
        if (c == CH_QUOTE) begin
          doc_mode = MODE_KSTR;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_KEY: begin
        if (ws_byte(c)) return 1'b1;
        if (c == CH_QUOTE) begin
          doc_mode = MODE_KSTR;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_COLON: begin
        if (ws_byte(c)) return 1'b1;
        if (c == CH_COLON) begin
          doc_mode = MODE_VALUE;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_AFTER: return value_done(c);
      MODE_VSTR, MODE_VESC, MODE_VHEX: return string_step(c, 1'b0);
      MODE_KSTR, MODE_KESC, MODE_KHEX: return string_step(c, 1'b1);
      MODE_LIT: begin
        if (lit_pos >= literal_length(lit_sel)) return 1'b0;
        if (c != literal_letter(lit_sel, lit_pos)) return 1'b0;
        lit_pos++;
        if (lit_pos == literal_length(lit_sel)) begin
          lit_pos = 0;
          doc_mode = MODE_AFTER;
        end
        return 1'b1;
      end
      MODE_NUM_MINUS: begin
        if (c == CH_ZERO) begin
          doc_mode = MODE_NUM_ZERO;
          return 1'b1;
        end
        if (c inside {[CH_ONE:CH_NINE]}) begin
          doc_mode = MODE_NUM_INT;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_NUM_ZERO, MODE_NUM_INT: begin
        // a leading zero takes no further integer digits
        if (doc_mode == MODE_NUM_INT && dec_digit(c)) return 1'b1;
        if (c == CH_DOT) begin
          doc_mode = MODE_NUM_DOT;
          return 1'b1;
        end
        if (exp_mark) begin
          doc_mode = MODE_NUM_EXP;
          return 1'b1;
        end
        return value_done(c);
      end
      MODE_NUM_DOT: begin
        if (dec_digit(c)) begin
          doc_mode = MODE_NUM_FRAC;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_NUM_FRAC: begin
        if (dec_digit(c)) return 1'b1;
        if (exp_mark) begin
          doc_mode = MODE_NUM_EXP;
          return 1'b1;
        end
        return value_done(c);
      end
      MODE_NUM_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          doc_mode = MODE_NUM_ESIGN;
          return 1'b1;
        end
        if (dec_digit(c)) begin
          doc_mode = MODE_NUM_EDIG;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_NUM_ESIGN: begin
        if (dec_digit(c)) begin
          doc_mode = MODE_NUM_EDIG;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_NUM_EDIG: begin
        if (dec_digit(c)) return 1'b1;
        return value_done(c);
      end
      default: return 1'b0;
    endcase
  endfunction

  // Work out the result that one accepted byte must produce.
  function automatic verdict_t judge_byte(logic [7:0] c, logic last);
    verdict_t    v;
    logic [31:0] here, next;
    here = doc_offset;
    next = (doc_offset == 32'hFFFF_FFFF) ? here : here + 32'd1;
    v.status = STATUS_RUNNING;
    if (!doc_failed) begin
      if (!take_byte(c)) begin
        doc_failed = 1'b1;
        fail_offset = here;
      end
    end
    // at the last byte only a finished value with nothing open is accepted
    if (last && !doc_failed) begin
      if (open_n == 0 && doc_mode inside {MODE_AFTER, MODE_NUM_ZERO, MODE_NUM_INT,
                                           MODE_NUM_FRAC, MODE_NUM_EDIG}) begin
        v.status = STATUS_ACCEPTED;
      end else begin
        doc_failed = 1'b1;
        fail_offset = next;
      end
    end
    doc_offset = next;
    if (doc_failed) v.status = STATUS_ERROR;
    v.offset = doc_failed ? fail_offset : 32'd0;
    v.level = 5'(open_n);
    if (last) forget_document();
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted byte, compare every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    verdict_t due;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) depth_lim = cfg_data_i;
      if (in_valid_i && !in_stall_o) verdicts_due.push_back(judge_byte(data_byte_i, last_byte_i));
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: result transaction with nothing predicted (status %0d)",
                   $time, status_o);
          failures++;
        end else begin
          due = verdicts_due.pop_front();
          if (status_o !== due.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, due.status, status_o);
            failures++;
          end
          if (error_offset_o !== due.offset) begin
            $display("%0t ns: error_offset expected %0d, got %0d",
                     $time, due.offset, error_offset_o);
            failures++;
          end
          if (nesting_level_o !== due.level) begin
            $display("%0t ns: nesting_level expected %0d, got %0d",
                     $time, due.level, nesting_level_o);
            failures++;
          end
        end
      end
    end
  end

  // Result sink: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source and configuration writes
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    // hold the transaction until the core takes it
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_document();
    for (int i = 0; i < doc_buf.size(); i++) send_byte(doc_buf[i], i == doc_buf.size() - 1);
  endtask

  // Drop the source, wait until every byte sent has produced its result, then let it settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_depth_limit(logic [4:0] lim);
    wait_drained();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gen_limit = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Document builder
  // ---------------------------------------------------------------------------
  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void put(logic [7:0] b);
    doc_buf.push_back(b);
  endfunction

  function automatic void put_word(string w);
    for (int i = 0; i < w.len(); i++) put(w[i]);
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'($urandom_range(CH_NINE, CH_ZERO));
  endfunction

  function automatic void put_ws();
    int unsigned n;
    if (!chance(25)) return;
    n = $urandom_range(2, 1);
    repeat (n) begin
      case ($urandom_range(3))
        0: put(CH_SPACE);
        1: put(CH_TAB);
        2: put(CH_LF);
        default: put(CH_CR);
      endcase
    end
  endfunction

  function automatic void put_string();
    int unsigned n, r;
    logic [7:0] c;
    string hex_set, esc_set;
    hex_set = "0123456789abcdefABCDEF";
    esc_set = "nrtbf\"\\/";
    put(CH_QUOTE);
    n = $urandom_range(5);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        c = 8'($urandom_range(8'h7E, CH_SPACE));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LO_A;
        put(c);
      end else if (r < 67) begin
        put(8'($urandom_range(8'hFF, 8'h7F)));   // DEL and upper half pass as they are
      end else if (r < 85) begin
        put(CH_BSLASH);
        put(esc_set[$urandom_range(7)]);
      end else if (r < 97) begin
        put(CH_BSLASH);
        put(CH_LO_U);
        repeat (4) put(hex_set[$urandom_range(21)]);
      end else begin
        put(8'($urandom_range(8'h1F)));          // raw control byte: an error
      end
    end
    put(CH_QUOTE);
  endfunction

  function automatic void put_number();
    int unsigned n;
    if (chance(30)) put(CH_MINUS);
    if (chance(30)) begin
      put(CH_ZERO);
    end else begin
      put(8'($urandom_range(CH_NINE, CH_ONE)));
      n = $urandom_range(3);
      repeat (n) put(any_digit());
    end
    if (chance(40)) begin
      put(CH_DOT);
      n = $urandom_range(3, 1);
      repeat (n) put(any_digit());
    end
    if (chance(30)) begin
      put(chance(50) ? CH_LO_E : CH_UP_E);
      if (chance(60)) put(chance(50) ? CH_PLUS : CH_MINUS);
      n = $urandom_range(2, 1);
      repeat (n) put(any_digit());
    end
  endfunction

  function automatic void put_scalar();
    case ($urandom_range(4))
      0, 1: put_number();
      2: put_string();
      3: put_word(chance(50) ? "null" : "true");
      default: put_word("false");
    endcase
  endfunction

  function automatic void put_key();
    put_ws();
    put_string();
    put_ws();
    put(CH_COLON);
  endfunction

  // Build one well-formed document; deep ones head for the configured limit and past it.
  function automatic void gen_document();
    bit          obj_stack[$];
    int unsigned budget, open_pct, max_nest, eff;
    bit          deep, want_value, finished;
    doc_buf.delete();
    eff = (gen_limit < STACK_DEPTH) ? gen_limit : STACK_DEPTH;
    deep = ($urandom_range(9) == 0);
    max_nest = deep ? eff + 1 : $urandom_range(3, 1);
    open_pct = deep ? 97 : 35;
    budget = $urandom_range(8, 1);
    want_value = 1'b1;
    finished = 1'b0;
    put_ws();
    while (!finished) begin
      if (want_value) begin
        if (obj_stack.size() < max_nest && chance(open_pct)) begin
          obj_stack.push_back(chance(50));
          put(obj_stack[$] ? CH_LBRACE : CH_LBRACKET);
          put_ws();
          if (!deep && chance(20)) begin
            // empty container
            put(obj_stack[$] ? CH_RBRACE : CH_RBRACKET);
            obj_stack.pop_back();
            want_value = 1'b0;
          end else if (obj_stack[$]) begin
            put_key();
            put_ws();
          end
        end else begin
          put_scalar();
          want_value = 1'b0;
        end
      end else begin
        put_ws();
        if (obj_stack.size() == 0) begin
          finished = 1'b1;
        end else if (budget != 0 && chance(50)) begin
          put(CH_COMMA);
          put_ws();
          if (obj_stack[$]) put_key();
          put_ws();
          want_value = 1'b1;
        end else begin
          put(obj_stack[$] ? CH_RBRACE : CH_RBRACKET);
          obj_stack.pop_back();
        end
      end
      if (budget != 0) budget--;
    end
  endfunction

  // Break a share of the documents: overwrite, cut short, insert, or replace with noise.
  function automatic void mutate_document();
    int unsigned m, n;
    m = $urandom_range(99);
    if (m < 8) begin
      doc_buf[$urandom_range(doc_buf.size() - 1)] = 8'($urandom_range(255));
    end else if (m < 14) begin
      if (doc_buf.size() > 1) begin
        n = $urandom_range(doc_buf.size() - 1, 1);
        while (doc_buf.size() > n) void'(doc_buf.pop_back());
      end
    end else if (m < 18) begin
      doc_buf.insert($urandom_range(doc_buf.size()), 8'($urandom_range(255)));
    end else if (m < 22) begin
      doc_buf.delete();
      n = $urandom_range(6, 1);
      repeat (n) put(8'($urandom_range(255)));
    end
  endfunction

  function automatic logic [4:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 5'd0;
    if (r < 20) return 5'd1;
    if (r < 35) return 5'd24;
    if (r < 50) return 5'($urandom_range(31, 25));   // above the stack: acts as the stack depth
    return 5'($urandom_range(23, 2));
  endfunction

  task automatic send_text(string s);
    doc_buf.delete();
    put_word(s);
    send_document();
  endtask

  task automatic run_random_docs(int unsigned bytes_wanted);
    int unsigned sent_here, docs;
    sent_here = 0;
    docs = 0;
    while (sent_here < bytes_wanted) begin
      if (docs % 40 == 0) set_depth_limit(pick_limit());
      gen_document();
      mutate_document();
      sent_here += doc_buf.size();
      send_document();
      docs++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_depth_limits();
    set_depth_limit(5'd1);
    send_text("[]");        // empty container at the limit: accepted
    send_text("[0]");       // value one level too deep, closing bracket then ignored
    set_depth_limit(5'd0);
    send_text("1");         // a zero limit refuses every value
    set_depth_limit(5'd31);
    send_text("[[]]");
    set_depth_limit(5'd24);
  endtask

  task automatic test_string_bytes();
    doc_buf = '{CH_QUOTE, 8'h7F, 8'hFF, CH_QUOTE};
    send_document();
    doc_buf = '{8'h00};
    send_document();
    send_text("tru");       // unfinished literal at the last byte
  endtask

  task automatic test_whitespace_and_numbers();
    doc_buf = '{CH_TAB, CH_LF, CH_CR, CH_SPACE};   // whitespace only: error past the end
    send_document();
    send_text("-0E+3");     // number closed by the last byte
  endtask

  // Hold the sink off for a long stretch while the source keeps offering bytes.
  task automatic test_output_backpressure();
    wait_drained();
    hold_req = 64;
    send_text("[1,22,333,true,\"ab\",{}]");
  endtask

  task automatic test_random_slow_sink();
    send_gap_pct = 13;
    stall_pct = 56;
    run_random_docs(600);
  endtask

  task automatic test_random_slow_source();
    send_gap_pct = 56;
    stall_pct = 13;
    run_random_docs(600);
  endtask

  task automatic test_random_no_idle();
    send_gap_pct = 0;
    stall_pct = 0;
    run_random_docs(620);
  endtask

  initial begin
    forget_document();
    send_gap_pct = 13;
    stall_pct = 56;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_depth_limits();
    test_string_bytes();
    test_whitespace_and_numbers();
    test_output_backpressure();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_no_idle();

    wait_drained();
    if (verdicts_due.size() != 0) begin
      $display("%0t ns: %0d predicted results never arrived", $time, verdicts_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("json_syntax_validator_core regression: pass");
    end else begin
      $display("json_syntax_validator_core regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #RUN_LIMIT_NS;
    $display("json_syntax_validator_core regression: fail");
    $finish;
  end

endmodule
